### rtl/cpd_pkg.sv
// Package for the closest pair distance unit: sizes, widths and status codes.
// No dependencies; imported by closest_pair_distance_unit.
package cpd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 33;
  localparam int RT_W       = 17;
  localparam int ST_W       = 2;
  localparam int MIN_W      = SQ_W + 1;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int RAD_W      = 2 * RT_W;
  localparam int REM_W      = RT_W + 3;
  localparam int STEP_W     = $clog2(RT_W + 1);

  typedef logic [ST_W-1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FEW     = 2'd1;
  localparam status_t ST_DROPPED = 2'd2;

endpackage

### rtl/closest_pair_distance_unit.sv
// Closest pair distance unit: point store, pair sequencer, shared squarer
// and bit-pair square root. Depends on cpd_pkg.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, point_x_i,       | item in
//          | point_y_i, last_point_i                  |
//  out     | out_valid_o, out_stall_i,                | item out
//          | min_sq_distance_o, min_distance_o,       |
//          | status_o                                 |
//
// Point items are loaded at one per cycle while in_stall_o is low. After the
// last item of a set of N stored points the sequencer walks every pair: a
// row step latches the first point, then each pair takes difference, square x,
// square y and compare steps through the single store read port and the one
// shared squarer, then the bit-pair square root runs on the minimum.
// Fewer than two points gives a result in the next cycle with no pair walk.
// Reset clears control state only; the point store is never cleared.
// While a result waits behind out_stall_i, further non-final items are still
// loaded into the next set; a final item is stalled until the result goes.
module closest_pair_distance_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cpd_pkg::IN_W-1:0]  point_x_i,
  input  logic [cpd_pkg::IN_W-1:0]  point_y_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cpd_pkg::SQ_W-1:0]  min_sq_distance_o,
  output logic [cpd_pkg::RT_W-1:0]  min_distance_o,
  output cpd_pkg::status_t          status_o
);
  import cpd_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_CAPI = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_SQX  = 3'd3;
  localparam logic [2:0] S_SQY  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_ROOT = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q;
  logic                  overflow_q;
  logic [MIN_W-1:0]      min_q;
  logic [IDX_W-1:0]      i_q, j_q;

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_q;
  logic [IDX_W-1:0]        raddr;

  logic [2*COORD_BITS-1:0] pi_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [PROD_W-1:0]       sqx_q, sqy_q;

  logic [RAD_W-1:0]      v_q;
  logic [REM_W-1:0]      rem_q;
  logic [RT_W-1:0]       root_q;
  logic [STEP_W-1:0]     step_q;

  logic [SQ_W-1:0]       res_sq_q;
  logic [RT_W-1:0]       res_rt_q;
  status_t               res_st_q;

  // input side
  logic in_take, full, wr_en, out_take, lone_take;
  assign in_stall_o = !((state_q == S_LOAD) || ((state_q == S_OUT) && !last_point_i));
  assign in_take    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(MAX_POINTS));
  assign wr_en      = in_take && !full;
  assign out_take   = out_valid_o && !out_stall_i;
  // final item of a set that held no point before it
  assign lone_take  = (state_q == S_LOAD) && in_take && last_point_i && (count_q == '0);

  // pair arithmetic
  logic [COORD_BITS-1:0] px, py, qx, qy;
  logic [COORD_BITS-1:0] mul_a;
  logic [PROD_W-1:0]     prod;
  logic [SQ_W-1:0]       pair_sq;
  logic [MIN_W-1:0]      min_new;
  logic [CNT_W-1:0]      j_next, i_next2;

  assign px = pi_q[COORD_BITS-1:0];
  assign py = pi_q[2*COORD_BITS-1:COORD_BITS];
  assign qx = rd_q[COORD_BITS-1:0];
  assign qy = rd_q[2*COORD_BITS-1:COORD_BITS];

  assign mul_a   = (state_q == S_SQX) ? dx_q : dy_q;
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_a);
  assign pair_sq = SQ_W'(sqx_q) + SQ_W'(sqy_q);
  assign min_new = (MIN_W'(pair_sq) < min_q) ? MIN_W'(pair_sq) : min_q;
  assign j_next  = CNT_W'(j_q) + CNT_W'(1);
  assign i_next2 = CNT_W'(i_q) + CNT_W'(2);

  // square root digit step: two radicand bits a cycle
  logic [REM_W-1:0] rem_sh, trial;
  logic             root_ge;
  assign rem_sh  = {rem_q[REM_W-3:0], v_q[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_q, 2'b01});
  assign root_ge = (rem_sh >= trial);

  logic [RT_W-1:0] root_step;
  assign root_step = {root_q[RT_W-2:0], root_ge};

  // store read address
  always_comb begin
    raddr = '0;
    unique case (state_q)
      S_CAPI:  raddr = IDX_W'(CNT_W'(i_q) + CNT_W'(1));
      S_CMP:   raddr = (j_next < count_q) ? j_next[IDX_W-1:0]
                                          : IDX_W'(CNT_W'(i_q) + CNT_W'(1));
      default: raddr = '0;
    endcase
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_W-1:0]] <= {point_y_i[COORD_BITS-1:0], point_x_i[COORD_BITS-1:0]};
    end
    rd_q <= mem[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_take && last_point_i) begin
          state_d = (count_q == '0) ? S_OUT : S_CAPI;
        end
      end
      S_CAPI: state_d = S_DIFF;
      S_DIFF: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_CMP;
      S_CMP: begin
        priority if (j_next < count_q) begin
          state_d = S_DIFF;
        end else if (i_next2 < count_q) begin
          state_d = S_CAPI;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (step_q == STEP_W'(RT_W - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_take) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      overflow_q <= 1'b0;
      min_q      <= '1;
      i_q        <= '0;
      j_q        <= '0;
      step_q     <= '0;
    end else begin
      state_q <= state_d;

      // a lone final point is not counted: the set starts afresh at zero
      if (wr_en && !lone_take) count_q <= count_q + CNT_W'(1);
      if (in_take && full) overflow_q <= 1'b1;

      unique case (state_q)
        S_LOAD: begin
          if (in_take && last_point_i) begin
            i_q <= '0;
            if (count_q == '0) begin
              // single point: result now, set starts afresh
              overflow_q <= 1'b0;
            end
          end
        end
        S_CAPI: j_q <= IDX_W'(CNT_W'(i_q) + CNT_W'(1));
        S_CMP: begin
          min_q <= min_new;
          if (j_next < count_q) begin
            j_q <= j_next[IDX_W-1:0];
          end else begin
            i_q <= IDX_W'(CNT_W'(i_q) + CNT_W'(1));
          end
          step_q <= '0;
        end
        S_ROOT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(RT_W - 1)) begin
            count_q    <= '0;
            overflow_q <= 1'b0;
            min_q      <= '1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_LOAD: begin
        if (in_take && last_point_i && (count_q == '0)) begin
          res_sq_q <= '0;
          res_rt_q <= '0;
          res_st_q <= ST_FEW;
        end
      end
      S_CAPI: pi_q <= rd_q;
      S_DIFF: begin
        dx_q <= (px > qx) ? (px - qx) : (qx - px);
        dy_q <= (py > qy) ? (py - qy) : (qy - py);
      end
      S_SQX: sqx_q <= prod;
      S_SQY: sqy_q <= prod;
      S_CMP: begin
        v_q    <= RAD_W'(min_new[SQ_W-1:0]);
        rem_q  <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        v_q    <= {v_q[RAD_W-3:0], 2'b00};
        rem_q  <= root_ge ? (rem_sh - trial) : rem_sh;
        root_q <= root_step;
        if (step_q == STEP_W'(RT_W - 1)) begin
          res_sq_q <= min_q[SQ_W-1:0];
          res_rt_q <= root_step;
          res_st_q <= overflow_q ? ST_DROPPED : ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = (state_q == S_OUT);
  assign min_sq_distance_o = res_sq_q;
  assign min_distance_o    = res_rt_q;
  assign status_o          = res_st_q;

endmodule

### sim/tb_closest_pair_distance_unit.sv
// Self-checking testbench for closest_pair_distance_unit: a directed table of
// point sets, one set past store capacity, then random sets, most with gaps.
// Depends on cpd_pkg and closest_pair_distance_unit.
`timescale 1ns / 1ps

module tb_closest_pair_distance_unit;
  import cpd_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [RT_W-1:0] rt;
    status_t         st;
  } pair_result_t;

  // one row of the directed table; fixed_res is used when has_fixed is set
  typedef struct {
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic            last;
    bit              has_fixed;
    pair_result_t    fixed_res;
  } point_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [IN_W-1:0]   point_x_i = '0;
  logic [IN_W-1:0]   point_y_i = '0;
  logic              last_point_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SQ_W-1:0]   min_sq_distance_o;
  logic [RT_W-1:0]   min_distance_o;
  status_t           status_o;

  closest_pair_distance_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .min_sq_distance_o(min_sq_distance_o),
    .min_distance_o   (min_distance_o),
    .status_o         (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog. The slowest legal run is dominated by the one full store walk.
  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: the set being loaded, mirrored from accepted items
  // ---------------------------------------------------------------------
  logic [COORD_BITS-1:0] set_x [MAX_POINTS];
  logic [COORD_BITS-1:0] set_y [MAX_POINTS];
  int unsigned           set_count = 0;
  bit                    set_dropped = 1'b0;

  pair_result_t pending_results [$];
  int           fail_count = 0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = RT_W - 1; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Brute-force minimum over every distinct pair of the stored points.
  function automatic pair_result_t closest_in_set();
    pair_result_t    res;
    longint unsigned best, dx, dy, d;
    best = '1;
    for (int i = 0; i < set_count; i++) begin
      for (int j = i + 1; j < set_count; j++) begin
        dx = (set_x[i] > set_x[j]) ? set_x[i] - set_x[j] : set_x[j] - set_x[i];
        dy = (set_y[i] > set_y[j]) ? set_y[i] - set_y[j] : set_y[j] - set_y[i];
        d  = dx * dx + dy * dy;
        if (d < best) best = d;
      end
    end
    res.sq = best[SQ_W-1:0];
    res.rt = RT_W'(floor_root(best));
    res.st = set_dropped ? ST_DROPPED : ST_OK;
    return res;
  endfunction

  // Called once per accepted item; a final item queues the expected result.
  task automatic take_point(input point_row_t row);
    pair_result_t res;
    if (set_count < MAX_POINTS) begin
      set_x[set_count] = row.x[COORD_BITS-1:0];
      set_y[set_count] = row.y[COORD_BITS-1:0];
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (row.last) begin
      if (set_count < 2) begin
        res = '{sq: '0, rt: '0, st: ST_FEW};
      end else begin
        res = closest_in_set();
      end
      pending_results.push_back(row.has_fixed ? row.fixed_res : res);
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Idling: mostly none or short, now and then long
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall: alternating stall and free runs, with long free stretches.
  int stall_left = 0;
  int free_left  = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0 && free_left == 0) begin
      free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : pick_gap();
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (free_left > 0) free_left--;
      out_stall_i <= 1'b0;
    end
  end

  // Drive one item at a falling edge, hold it until accepted at a rising edge.
  task automatic send_point(input point_row_t row, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= row.x;
    point_y_i    <= row.y;
    last_point_i <= row.last;
    do @(posedge clk_i); while (in_stall_o);
    take_point(row);
  endtask

  // Sender holds off until every queued result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic point_row_t plain_row(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                           logic last);
    point_row_t row;
    row.x         = x;
    row.y         = y;
    row.last      = last;
    row.has_fixed = 1'b0;
    row.fixed_res = '0;
    return row;
  endfunction

  function automatic point_row_t fixed_row(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                           pair_result_t res);
    point_row_t row;
    row           = plain_row(x, y, 1'b1);
    row.has_fixed = 1'b1;
    row.fixed_res = res;
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted result
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    pair_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got sq %0d root %0d status %0d",
                 $time, min_sq_distance_o, min_distance_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (min_sq_distance_o !== want.sq) begin
          $display("%0t: min_sq_distance expected %0d got %0d",
                   $time, want.sq, min_sq_distance_o);
          fail_count++;
        end
        if (min_distance_o !== want.rt) begin
          $display("%0t: min_distance expected %0d got %0d", $time, want.rt, min_distance_o);
          fail_count++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, status_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    point_row_t       table_rows [$];
    point_row_t       row;
    int               n, items_done, r;
    bit               clustered, no_gaps;
    logic [IN_W-1:0]  base_x, base_y, px, py;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. A lone point straight after reset: too few points.
    table_rows.push_back(fixed_row(16'd1234, 16'd4321, '{sq: '0, rt: '0, st: ST_FEW}));
    // opposite corners: largest possible distance
    table_rows.push_back(plain_row(16'd0, 16'd0, 1'b0));
    table_rows.push_back(fixed_row(16'hFFFF, 16'hFFFF,
                                   '{sq: 33'd8589672450, rt: 17'd92680, st: ST_OK}));
    // full span on one axis only
    table_rows.push_back(plain_row(16'd0, 16'd0, 1'b0));
    table_rows.push_back(fixed_row(16'hFFFF, 16'd0,
                                   '{sq: 33'd4294836225, rt: 17'd65535, st: ST_OK}));
    // coincident points give zero
    table_rows.push_back(plain_row(16'd7, 16'd9, 1'b0));
    table_rows.push_back(fixed_row(16'd7, 16'd9, '{sq: '0, rt: '0, st: ST_OK}));
    // 3-4-5 triangle, the nearest pair first
    table_rows.push_back(plain_row(16'd100, 16'd200, 1'b0));
    table_rows.push_back(plain_row(16'd103, 16'd204, 1'b0));
    table_rows.push_back(fixed_row(16'd5000, 16'd5000, '{sq: 33'd25, rt: 17'd5, st: ST_OK}));
    // nearest pair is first and last
    table_rows.push_back(plain_row(16'd40000, 16'd12, 1'b0));
    table_rows.push_back(plain_row(16'd39990, 16'd30000, 1'b0));
    table_rows.push_back(plain_row(16'd12, 16'hFFFF, 1'b0));
    table_rows.push_back(plain_row(16'd40001, 16'd13, 1'b1));
    // alternating bit patterns
    table_rows.push_back(plain_row(16'hAAAA, 16'h5555, 1'b0));
    table_rows.push_back(plain_row(16'h5555, 16'hAAAA, 1'b1));
    table_rows.push_back(fixed_row(16'hFFFF, 16'd0, '{sq: '0, rt: '0, st: ST_FEW}));

    foreach (table_rows[i]) send_point(table_rows[i], pick_gap());

    // One set past capacity: the last two points, the final one among them,
    // are dropped and the minimum is over the full store.
    drain_results();
    for (int k = 0; k < MAX_POINTS + 2; k++) begin
      send_point(plain_row(IN_W'($urandom), IN_W'($urandom), k == MAX_POINTS + 1),
                 ($urandom_range(0, 19) == 0) ? pick_gap() : 0);
    end

    // Random sets, mostly small so the pair walk stays short.
    items_done = 0;
    while (items_done < 450) begin
      r = $urandom_range(0, 99);
      if (r < 10)      n = 1;
      else if (r < 85) n = $urandom_range(2, 8);
      else             n = $urandom_range(9, 40);
      clustered = $urandom_range(0, 1);
      no_gaps   = ($urandom_range(0, 3) == 0);
      base_x    = IN_W'($urandom_range(0, 65535 - 31));
      base_y    = IN_W'($urandom_range(0, 65535 - 31));
      if ($urandom_range(0, 24) == 0) drain_results();
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0 && k > 0) begin
          // repeat the previous point now and then
        end else if (clustered) begin
          px = base_x + IN_W'($urandom_range(0, 31));
          py = base_y + IN_W'($urandom_range(0, 31));
        end else begin
          px = IN_W'($urandom);
          py = IN_W'($urandom);
        end
        row = plain_row(px, py, k == n - 1);
        send_point(row, no_gaps ? 0 : pick_gap());
        items_done++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // room for a stray result to show up
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
